[rtl/pcf_pkg.sv]
// pcf_pkg: shared types and constants of the pixel colour fade engine
// field widths, command codes and the status record of the arithmetic units
// no dependencies
package pcf_pkg;

    localparam int CMD_W   = 2;
    localparam int COLOR_W = 8;
    localparam int DUR_W   = 32;
    localparam int STEP_W  = 16;
    localparam int NUM_CH  = 4;
    localparam int CH_IDX_W = $clog2(NUM_CH);

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FADE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

[rtl/pcf_ifs.sv]
// pcf_in_if and pcf_out_if: valid/ready channels of the fade engine
// command item in, colour item out
// depends on pcf_pkg
interface pcf_in_if;
    logic                          valid;
    logic                          ready;
    logic [pcf_pkg::CMD_W-1:0]     command;
    logic [pcf_pkg::COLOR_W-1:0]   red;
    logic [pcf_pkg::COLOR_W-1:0]   green;
    logic [pcf_pkg::COLOR_W-1:0]   blue;
    logic [pcf_pkg::COLOR_W-1:0]   brightness;
    logic [pcf_pkg::DUR_W-1:0]     duration;
    logic [pcf_pkg::STEP_W-1:0]    time_step;

    modport source (output valid, command, red, green, blue, brightness, duration,
                    time_step, input ready);
    modport sink (input valid, command, red, green, blue, brightness, duration,
                  time_step, output ready);
endinterface

interface pcf_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcf_pkg::COLOR_W-1:0]   out_red;
    logic [pcf_pkg::COLOR_W-1:0]   out_green;
    logic [pcf_pkg::COLOR_W-1:0]   out_blue;
    logic [pcf_pkg::COLOR_W-1:0]   out_brightness;
    logic                          fading;

    modport source (output valid, out_red, out_green, out_blue, out_brightness, fading,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_brightness, fading,
                  output ready);
endinterface

[rtl/pcf_div.sv]
// pcf_div: restoring divider for the fade fraction, one quotient bit per cycle
// gives floor(min(a, d) * 2^FRAC_W / d) for d > 0 in FRAC_W + 1 steps
// depends on pcf_pkg
module pcf_div #(
    parameter int FRAC_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcf_pkg::DUR_W-1:0]     i_dividend,
    input  logic [pcf_pkg::DUR_W-1:0]     i_divisor,
    output pcf_pkg::t_unit_sts            o_sts,
    output logic [FRAC_W:0]               o_quot
);
    localparam int CNT_W = $clog2(FRAC_W + 2);
    localparam int DW    = pcf_pkg::DUR_W;

    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     n_rem;
    logic [DW-1:0]     r_div;
    logic [FRAC_W:0]   r_quot;
    logic [FRAC_W:0]   n_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_first;
    logic              r_done;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;

    // first step is the integer bit, the rest shift the remainder
    assign w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign n_quot  = {r_quot[FRAC_W-1:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= CNT_W'(FRAC_W + 1);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (i_dividend >= i_divisor) ? i_divisor : i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

[rtl/pcf_blend.sv]
// pcf_blend: one shared multiplier blends the four channels in turn
// each channel: product cycle, then add or subtract of the truncated part
// depends on pcf_pkg
module pcf_blend #(
    parameter int CH_W   = 8,
    parameter int FRAC_W = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [FRAC_W:0]                       i_frac,
    input  logic [pcf_pkg::NUM_CH-1:0][CH_W-1:0]  i_from,
    input  logic [pcf_pkg::NUM_CH-1:0][CH_W-1:0]  i_to,
    output pcf_pkg::t_unit_sts                    o_sts,
    output logic [pcf_pkg::NUM_CH-1:0][CH_W-1:0]  o_col
);
    localparam int IW = pcf_pkg::CH_IDX_W;

    logic [IW-1:0]                          r_idx;
    logic                                   r_phase;
    logic                                   r_busy;
    logic                                   r_done;
    logic [FRAC_W:0]                        r_frac;
    logic [CH_W+FRAC_W:0]                   r_prod;
    logic                                   r_up;
    logic [pcf_pkg::NUM_CH-1:0][CH_W-1:0]   r_res;
    logic [CH_W-1:0]                        w_s;
    logic [CH_W-1:0]                        w_t;
    logic                                   w_up;
    logic [CH_W-1:0]                        w_mag;
    logic [CH_W-1:0]                        w_part;

    assign w_s    = i_from[r_idx];
    assign w_t    = i_to[r_idx];
    assign w_up   = w_t >= w_s;
    assign w_mag  = w_up ? (w_t - w_s) : (w_s - w_t);
    assign w_part = r_prod[FRAC_W +: CH_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= r_busy && !i_start && r_phase
                      && (r_idx == IW'(pcf_pkg::NUM_CH - 1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_idx   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_idx == IW'(pcf_pkg::NUM_CH - 1)) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_frac <= i_frac;
        end
        if (r_busy && !r_phase) begin
            r_prod <= w_mag * r_frac;
            r_up   <= w_up;
        end
        if (r_busy && r_phase) begin
            r_res[r_idx] <= r_up ? (w_s + w_part) : (w_s - w_part);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_col      = r_res;

endmodule

[rtl/pixel_color_fade.sv]
// pixel_color_fade: one-pixel linear colour crossfade engine, top level
// sequencer, colour and timing state, output register
// depends on pcf_pkg, pcf_ifs, pcf_div, pcf_blend
//
// Takes one command item at a time and returns one colour item for each. Set,
// fade, a tick outside a fade, a tick that ends a fade and command three load
// their result into the output register from the emit state once that register
// is free. A tick that advances a fade runs the fraction through a bit-serial
// divider and then blends the four channels through one shared multiplier, so
// its result is loaded only after both units have finished. The block takes a
// new item as soon as its sequencer is idle, which it becomes as the last result
// is loaded, also while that result still waits in the output register.
module pixel_color_fade #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcf_in_if.sink     i_in,
    pcf_out_if.source  o_out
);
    localparam int CH_W = CHANNEL_BITS;
    localparam int CW   = pcf_pkg::COLOR_W;
    localparam int DW   = pcf_pkg::DUR_W;
    localparam int NCH  = pcf_pkg::NUM_CH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVGO = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [NCH-1:0][CH_W-1:0]   r_cur;
    logic [NCH-1:0][CH_W-1:0]   r_from;
    logic [NCH-1:0][CH_W-1:0]   r_to;
    logic [DW-1:0]              r_elapsed;
    logic [DW-1:0]              r_len;
    logic                       r_active;
    logic [NCH-1:0][CW-1:0]     r_out_col;
    logic                       r_out_fading;
    logic                       r_out_valid;

    logic                       w_acc;
    logic [NCH-1:0][CW-1:0]     w_in_raw;
    logic [NCH-1:0][CH_W-1:0]   w_in_col;
    logic [NCH-1:0][CW-1:0]     w_cur_out;
    logic [DW:0]                w_sum;
    logic [DW-1:0]              w_new_elapsed;
    logic                       w_reached;
    logic                       w_out_free;
    logic                       w_load_out;

    pcf_pkg::t_unit_sts         div_sts;
    pcf_pkg::t_unit_sts         bl_sts;
    logic [FRACTION_BITS:0]     div_quot;
    logic [NCH-1:0][CH_W-1:0]   bl_col;

    assign w_acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    assign w_in_raw[0] = i_in.red;
    assign w_in_raw[1] = i_in.green;
    assign w_in_raw[2] = i_in.blue;
    assign w_in_raw[3] = i_in.brightness;

    for (genvar g = 0; g < NCH; g++) begin : g_ch
        logic [CW+CH_W-1:0] w_in_ext;
        logic [CW+CH_W-1:0] w_out_ext;
        assign w_in_ext     = {{CH_W{1'b0}}, w_in_raw[g]};
        assign w_in_col[g]  = w_in_ext[CH_W-1:0];
        assign w_out_ext    = {{CW{1'b0}}, r_cur[g]};
        assign w_cur_out[g] = w_out_ext[CW-1:0];
    end

    // saturating advance and completion test run side by side
    assign w_sum         = {1'b0, r_elapsed} + {{(DW + 1 - pcf_pkg::STEP_W){1'b0}},
                                                i_in.time_step};
    assign w_new_elapsed = w_sum[DW] ? {DW{1'b1}} : w_sum[DW-1:0];
    assign w_reached     = r_elapsed >= r_len;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load_out = (r_state == ST_EMIT) && w_out_free;

    pcf_div #(
        .FRAC_W (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIVGO),
        .i_dividend (r_elapsed),
        .i_divisor  (r_len),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    pcf_blend #(
        .CH_W   (CH_W),
        .FRAC_W (FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_sts.done),
        .i_frac  (div_quot),
        .i_from  (r_from),
        .i_to    (r_to),
        .o_sts   (bl_sts),
        .o_col   (bl_col)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in.command == pcf_pkg::CMD_TICK && r_active && !w_reached) begin
                        n_state = ST_DIVGO;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIVGO: n_state = ST_DIV;
            ST_DIV: begin
                if (div_sts.done) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (bl_sts.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_from      <= '0;
            r_to        <= '0;
            r_elapsed   <= '0;
            r_len       <= DW'(1);
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                priority if (i_in.command == pcf_pkg::CMD_SET) begin
                    r_cur    <= w_in_col;
                    r_active <= 1'b0;
                end else if (i_in.command == pcf_pkg::CMD_FADE) begin
                    r_from    <= r_cur;
                    r_to      <= w_in_col;
                    r_len     <= (i_in.duration == '0) ? DW'(1) : i_in.duration;
                    r_elapsed <= '0;
                    r_active  <= 1'b1;
                end else if (i_in.command == pcf_pkg::CMD_TICK && r_active) begin
                    if (w_reached) begin
                        r_active <= 1'b0;
                    end else begin
                        r_elapsed <= w_new_elapsed;
                    end
                end else begin
                    r_active <= r_active;
                end
            end
            if (r_state == ST_BLEND && bl_sts.done) begin
                r_cur <= bl_col;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_col    <= w_cur_out;
            r_out_fading <= r_active;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_red        = r_out_col[0];
    assign o_out.out_green      = r_out_col[1];
    assign o_out.out_blue       = r_out_col[2];
    assign o_out.out_brightness = r_out_col[3];
    assign o_out.fading         = r_out_fading;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> r_state == ST_DIV)
        else $error("divider finished outside its wait state");

    a_blend_done_in_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bl_sts.done |-> r_state == ST_BLEND)
        else $error("blend finished outside its wait state");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !div_sts.busy && !bl_sts.busy)
        else $error("arithmetic unit busy while sequencer idle");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> div_quot <= FRAC_ONE)
        else $error("fade fraction above one");

    a_fade_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in.command == pcf_pkg::CMD_FADE |=> r_active && r_elapsed == '0)
        else $error("fade command did not start a fade");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == ST_EMIT)
        else $error("result item raised outside emit");

endmodule

[bench/pcf_fade_sb_pkg.sv]
`timescale 1ns / 1ps
// pcf_fade_sb_pkg: item types and the scoreboard of the fade engine testbench
// depends on pcf_pkg
package pcf_fade_sb_pkg;
    import pcf_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]                command;
        logic [NUM_CH-1:0][COLOR_W-1:0]  color;
        logic [DUR_W-1:0]                duration;
        logic [STEP_W-1:0]               time_step;
    } fade_cmd_t;

    typedef struct packed {
        logic [NUM_CH-1:0][COLOR_W-1:0]  color;
        logic                            fading;
    } pixel_out_t;

    class fade_scoreboard;
        logic [NUM_CH-1:0][COLOR_W-1:0] now_col;
        logic [NUM_CH-1:0][COLOR_W-1:0] start_col;
        logic [NUM_CH-1:0][COLOR_W-1:0] target_col;
        logic [DUR_W-1:0]               elapsed;
        logic [DUR_W-1:0]               length;
        logic                           fading;
        pixel_out_t                     expected_q[$];
        int                             errors;
        int                             reported;

        function new();
            now_col    = '0;
            start_col  = '0;
            target_col = '0;
            elapsed    = '0;
            length     = '0;
            fading     = 1'b0;
            errors     = 0;
            reported   = 0;
        endfunction

        // linear mix of one channel, truncated toward zero
        function logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] s, logic [COLOR_W-1:0] t,
                                         logic [FRAC_BITS:0] frac);
            logic [63:0] part;
            if (t >= s) begin
                part = ((64'(t) - 64'(s)) * 64'(frac)) >> FRAC_BITS;
                return s + part[COLOR_W-1:0];
            end
            part = ((64'(s) - 64'(t)) * 64'(frac)) >> FRAC_BITS;
            return s - part[COLOR_W-1:0];
        endfunction

        function void note_command(fade_cmd_t c);
            logic [DUR_W-1:0]   span;
            logic [DUR_W-1:0]   used;
            logic [63:0]        quot;
            pixel_out_t         exp_item;
            case (c.command)
                CMD_SET: begin
                    now_col = c.color;
                    fading  = 1'b0;
                end
                CMD_FADE: begin
                    start_col  = now_col;
                    target_col = c.color;
                    length     = c.duration;
                    elapsed    = '0;
                    fading     = 1'b1;
                end
                CMD_TICK: begin
                    if (fading) begin
                        span = (length == '0) ? DUR_W'(1) : length;
                        if (elapsed >= span) begin
                            fading = 1'b0;
                        end else begin
                            if (elapsed > {DUR_W{1'b1}} - DUR_W'(c.time_step))
                                elapsed = {DUR_W{1'b1}};
                            else
                                elapsed = elapsed + DUR_W'(c.time_step);
                            used = (elapsed < span) ? elapsed : span;
                            quot = (64'(used) << FRAC_BITS) / 64'(span);
                            for (int i = 0; i < NUM_CH; i++)
                                now_col[i] = mix(start_col[i], target_col[i],
                                                 quot[FRAC_BITS:0]);
                        end
                    end
                end
                default: ;
            endcase
            exp_item.color  = now_col;
            exp_item.fading = fading;
            expected_q.push_back(exp_item);
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t exp_item;
            if (expected_q.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected item: color %h fading %b", got.color, got.fading);
                end
                return;
            end
            exp_item = expected_q.pop_front();
            for (int i = 0; i < NUM_CH; i++) begin
                if (got.color[i] !== exp_item.color[i]) begin
                    errors++;
                    if (reported < 10) begin
                        reported++;
                        $display("channel %0d mismatch: expected %h actual %h",
                                 i, exp_item.color[i], got.color[i]);
                    end
                end
            end
            if (got.fading !== exp_item.fading) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("fading mismatch: expected %b actual %b",
                             exp_item.fading, got.fading);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

[bench/pixel_color_fade_tb.sv]
`timescale 1ns / 1ps
// pixel_color_fade_tb: directed and random regression of the pixel colour fade engine
// depends on pcf_pkg, pcf_ifs, pcf_fade_sb_pkg and the pixel_color_fade rtl
module pixel_color_fade_tb;
    import pcf_pkg::*;
    import pcf_fade_sb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_ITEMS   = 1700;
    localparam int HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pcf_in_if  in_ch ();
    pcf_out_if out_ch ();

    pixel_color_fade dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fade_scoreboard pixel_sb;
    int  tx_idle_pct = 31;
    int  rx_idle_pct = 49;
    int  sent_count  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;
    bit  hold_req    = 1'b0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req     = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        pixel_out_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.color  = {out_ch.out_brightness, out_ch.out_blue, out_ch.out_green,
                          out_ch.out_red};
            got.fading = out_ch.fading;
            pixel_sb.check_result(got);
        end
    end

    function automatic fade_cmd_t rand_item(logic [CMD_W-1:0] cmd);
        fade_cmd_t c;
        c.command   = cmd;
        c.color     = $urandom;
        c.duration  = $urandom;
        c.time_step = STEP_W'($urandom);
        return c;
    endfunction

    function automatic fade_cmd_t mk_item(logic [CMD_W-1:0] cmd, logic [31:0] col,
                                          logic [DUR_W-1:0] dur, logic [STEP_W-1:0] step);
        fade_cmd_t c;
        c.command   = cmd;
        c.color     = col;
        c.duration  = dur;
        c.time_step = step;
        return c;
    endfunction

    task automatic send_cmd(fade_cmd_t c);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.command    = c.command;
        in_ch.red        = c.color[0];
        in_ch.green      = c.color[1];
        in_ch.blue       = c.color[2];
        in_ch.brightness = c.color[3];
        in_ch.duration   = c.duration;
        in_ch.time_step  = c.time_step;
        do @(posedge i_clk); while (!in_ch.ready);
        pixel_sb.note_command(c);
        if (c.command != CMD_NONE)
            sent_count++;
    endtask

    // fade followed by a run of ticks sized to its duration
    task automatic fade_run();
        fade_cmd_t c;
        longint    span;
        longint    step_hi;
        int        n_ticks;
        int        kind;
        c    = rand_item(CMD_FADE);
        kind = $urandom_range(9);
        if (kind == 0)
            c.duration = '0;
        else if (kind <= 5)
            c.duration = $urandom_range(1, 64);
        else if (kind <= 7)
            c.duration = $urandom_range(65, 200000);
        else if (kind == 9)
            c.duration = $urandom_range(1, 4);
        send_cmd(c);
        span    = (c.duration == 0) ? 1 : longint'(c.duration);
        n_ticks = $urandom_range(1, 10);
        step_hi = 2 * (span / n_ticks) + 1;
        if (step_hi > 65535)
            step_hi = 65535;
        n_ticks += $urandom_range(0, 2);
        repeat (n_ticks) begin
            c = rand_item(CMD_TICK);
            if ($urandom_range(9) != 0)
                c.time_step = STEP_W'($urandom_range(0, int'(step_hi)));
            send_cmd(c);
        end
    endtask

    initial begin
        int  pick;
        bit  hold_done;
        pixel_sb         = new();
        hold_done        = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_SET;
        in_ch.red        = '0;
        in_ch.green      = '0;
        in_ch.blue       = '0;
        in_ch.brightness = '0;
        in_ch.duration   = '0;
        in_ch.time_step  = '0;
        out_ch.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd5));
        send_cmd(mk_item(CMD_NONE, 32'hffffffff, 32'hffffffff, 16'hffff));
        send_cmd(mk_item(CMD_SET, 32'hffffffff, 32'h0, 16'h0));
        send_cmd(mk_item(CMD_SET, 32'h00000000, 32'hffffffff, 16'hffff));
        send_cmd(mk_item(CMD_SET, 32'h00ff5aa5, 32'h0, 16'h0));
        send_cmd(mk_item(CMD_FADE, 32'ha55aff00, 32'h0, 16'h0));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd0));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd1));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd3));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd9));
        send_cmd(mk_item(CMD_FADE, 32'hffffffff, 32'hffffffff, 16'h0));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'hffff));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'hffff));
        send_cmd(mk_item(CMD_NONE, 32'h12345678, 32'h0, 16'h0));
        send_cmd(mk_item(CMD_SET, 32'h40c08020, 32'h0, 16'h0));
        send_cmd(mk_item(CMD_FADE, 32'h00000000, 32'd1000, 16'h0));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd333));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd333));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'hffff));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd1));
        send_cmd(mk_item(CMD_FADE, 32'h7f80ed12, 32'd7, 16'h0));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd7));
        send_cmd(mk_item(CMD_TICK, 32'h0, 32'h0, 16'd0));
        send_cmd(mk_item(CMD_FADE, 32'h0, 32'h80000000, 16'h0));
        send_cmd(mk_item(CMD_NONE, 32'h0, 32'h0, 16'h0));

        while (sent_count < NUM_ITEMS) begin
            if (sent_count < NUM_ITEMS / 3) begin
                tx_idle_pct = 31;
                rx_idle_pct = 49;
            end else if (sent_count < 2 * NUM_ITEMS / 3) begin
                tx_idle_pct = 49;
                rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (!hold_done && sent_count >= 1300) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 15)
                send_cmd(rand_item(CMD_SET));
            else if (pick < 80)
                fade_run();
            else if (pick < 92)
                send_cmd(rand_item(CMD_TICK));
            else if (pick < 96)
                send_cmd(rand_item(CMD_FADE));
            else
                send_cmd(rand_item(CMD_NONE));
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pixel_sb.pending() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pixel_sb.errors == 0 && pixel_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
